// ===== rtl/core/cau_pkg.sv =====
// shared types, operation codes and saturation helpers for the complex arithmetic unit
package cau_pkg;

	typedef enum logic [3:0] {
		K_ADD     = 4'd0,
		K_SUB     = 4'd1,
		K_MUL     = 4'd2,
		K_DIV     = 4'd3,
		K_CONJ    = 4'd4,
		K_NEG     = 4'd5,
		K_SCALE   = 4'd6,
		K_MODSQ   = 4'd7,
		K_NONZERO = 4'd8,
		K_ISINF   = 4'd9
	} kind_t;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_INF = 2'd1;
	localparam logic [1:0] ST_NAN = 2'd2;

	localparam logic [31:0] POS_MAX = 32'h7fff_ffff;
	localparam logic [31:0] NEG_MIN = 32'h8000_0000;

	// quotient bits plus one range check stage
	localparam int QBITS      = 32;
	localparam int DIV_STAGES = QBITS + 1;

	typedef struct packed {
		logic [3:0]         kind;
		logic signed [31:0] a_re;
		logic signed [31:0] a_im;
		logic signed [31:0] b_re;
		logic signed [31:0] b_im;
		logic signed [31:0] scalar;
	} op_t;

	typedef struct packed {
		logic signed [31:0] res_re;
		logic signed [31:0] res_im;
		logic               flag;
		logic [1:0]         status;
	} res_t;

	// everything that rides alongside the divider
	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] re;
		logic [31:0] im;
		logic        flag;
		logic [1:0]  status;
		logic        neg_re;
		logic        neg_im;
		logic        div_ok;
	} side_t;

	function automatic logic [31:0] sat33(input logic [32:0] v);
		logic [31:0] r;
		if (v[32] != v[31]) begin
			r = v[32] ? NEG_MIN : POS_MAX;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// sign and magnitude to saturated two's complement
	function automatic logic [31:0] sat_sm(input logic neg, input logic [63:0] mag);
		logic [31:0] r;
		if (neg) begin
			r = (|mag[63:31]) ? NEG_MIN : 32'd0 - mag[31:0];
		end else begin
			r = (|mag[63:31]) ? POS_MAX : mag[31:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/cau_mult.sv =====
// first stage: operand products and the results that need no multiplier
module cau_mult import cau_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  op_t                op,
	output logic signed [63:0] p1_s1,
	output logic signed [63:0] p2_s1,
	output logic signed [63:0] p3_s1,
	output logic signed [63:0] p4_s1,
	output logic signed [63:0] p5_s1,
	output logic signed [63:0] p6_s1,
	output side_t              side_s1
);

	logic               is_scale;
	logic               is_modsq;
	logic signed [31:0] x1, y1, y2, x3, y3;
	logic               a_nz;
	side_t              side;

	assign is_scale = (op.kind == K_SCALE);
	assign is_modsq = (op.kind == K_MODSQ);
	assign x1 = is_scale ? op.scalar : op.a_re;
	assign y1 = (is_scale || is_modsq) ? op.a_re : op.b_re;
	assign y2 = is_modsq ? op.a_im : op.b_im;
	assign x3 = is_scale ? op.scalar : op.a_re;
	assign y3 = is_scale ? op.a_im : op.b_im;
	assign a_nz = (op.a_re != 32'sd0) || (op.a_im != 32'sd0);

	always_comb begin
		side = '0;
		side.kind = op.kind;
		case (op.kind)
			K_ADD: begin
				side.re = sat33({op.a_re[31], op.a_re} + {op.b_re[31], op.b_re});
				side.im = sat33({op.a_im[31], op.a_im} + {op.b_im[31], op.b_im});
			end
			K_SUB: begin
				side.re = sat33({op.a_re[31], op.a_re} - {op.b_re[31], op.b_re});
				side.im = sat33({op.a_im[31], op.a_im} - {op.b_im[31], op.b_im});
			end
			K_CONJ: begin
				side.re = op.a_re;
				side.im = sat33(33'd0 - {op.a_im[31], op.a_im});
			end
			K_NEG: begin
				side.re = sat33(33'd0 - {op.a_re[31], op.a_re});
				side.im = sat33(33'd0 - {op.a_im[31], op.a_im});
			end
			K_DIV: begin
				// zero divisor outcome, replaced later when the divisor is nonzero
				side.re = a_nz ? POS_MAX : 32'd0;
				side.status = a_nz ? ST_INF : ST_NAN;
			end
			K_NONZERO: side.flag = a_nz;
			K_ISINF:   side.flag = (op.a_re == POS_MAX) && (op.a_im == 32'sd0);
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1   <= x1 * y1;
			p2_s1   <= op.a_im * y2;
			p3_s1   <= x3 * y3;
			p4_s1   <= op.a_im * op.b_re;
			p5_s1   <= op.b_re * op.b_re;
			p6_s1   <= op.b_im * op.b_im;
			side_s1 <= side;
		end
	end

endmodule

// ===== rtl/core/cau_comb.sv =====
// second and third stages: product sums, sign and magnitude, multiply results
module cau_comb import cau_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic [1:0]         en,
	input  logic signed [63:0] p1_s1,
	input  logic signed [63:0] p2_s1,
	input  logic signed [63:0] p3_s1,
	input  logic signed [63:0] p4_s1,
	input  logic signed [63:0] p5_s1,
	input  logic signed [63:0] p6_s1,
	input  side_t              side_s1,
	output logic [63:0]        mag_re_s3,
	output logic [63:0]        mag_im_s3,
	output logic [63:0]        den_s3,
	output side_t              side_s3
);

	logic [64:0] e1, e2, e3, e4;
	logic [64:0] add_re, add_im, sre, sim;
	logic [64:0] sre_s2, sim_s2;
	logic [63:0] den_s2;
	side_t       side_s2;
	logic        neg_re, neg_im;
	logic [64:0] nre, nim;
	logic [63:0] mag_re, mag_im;
	side_t       side;

	assign e1 = {p1_s1[63], p1_s1};
	assign e2 = {p2_s1[63], p2_s1};
	assign e3 = {p3_s1[63], p3_s1};
	assign e4 = {p4_s1[63], p4_s1};

	always_comb begin
		case (side_s1.kind)
			K_MUL: begin
				add_re = 65'd0 - e2;
				add_im = e4;
			end
			K_DIV: begin
				add_re = e2;
				add_im = 65'd0 - e3;
			end
			K_MODSQ: begin
				add_re = e2;
				add_im = 65'd0;
			end
			default: begin
				add_re = 65'd0;
				add_im = 65'd0;
			end
		endcase
	end

	// for division the imaginary numerator is a_im*b_re - a_re*b_im
	assign sre = e1 + add_re;
	assign sim = (side_s1.kind == K_DIV) ? e4 + add_im : e3 + add_im;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			sre_s2  <= sre;
			sim_s2  <= sim;
			den_s2  <= p5_s1 + p6_s1;
			side_s2 <= side_s1;
		end
	end

	assign neg_re = sre_s2[64];
	assign neg_im = sim_s2[64];
	assign nre = 65'd0 - sre_s2;
	assign nim = 65'd0 - sim_s2;
	assign mag_re = neg_re ? nre[63:0] : sre_s2[63:0];
	assign mag_im = neg_im ? nim[63:0] : sim_s2[63:0];

	always_comb begin
		side = side_s2;
		side.neg_re = neg_re;
		side.neg_im = neg_im;
		case (side_s2.kind)
			K_MUL, K_SCALE: begin
				side.re = sat_sm(neg_re, mag_re >> FRAC_BITS);
				side.im = sat_sm(neg_im, mag_im >> FRAC_BITS);
			end
			K_MODSQ: begin
				side.re = sat_sm(neg_re, mag_re >> FRAC_BITS);
				side.im = 32'd0;
			end
			K_DIV: begin
				if (den_s2 != 64'd0) begin
					side.div_ok = 1'b1;
					side.re = 32'd0;
					side.status = ST_OK;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			mag_re_s3 <= mag_re;
			mag_im_s3 <= mag_im;
			den_s3    <= den_s2;
			side_s3   <= side;
		end
	end

endmodule

// ===== rtl/core/cau_div.sv =====
// restoring divider pipeline: a range check stage, then one quotient bit per stage, real and imaginary lanes
module cau_div import cau_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic [DIV_STAGES-1:0] en,
	input  logic [63:0]           mag_re,
	input  logic [63:0]           mag_im,
	input  logic [63:0]           den,
	input  side_t                 side_in,
	output logic [QBITS-1:0]      q_re,
	output logic [QBITS-1:0]      q_im,
	output logic                  ovf_re,
	output logic                  ovf_im,
	output side_t                 side_out
);

	localparam int NW = 64 + FRAC_BITS;

	logic [NW-1:0]      n_re, n_im;
	logic [63:0]        rem_re_s [DIV_STAGES];
	logic [63:0]        rem_im_s [DIV_STAGES];
	logic [QBITS-1:0]   lo_re_s  [DIV_STAGES];
	logic [QBITS-1:0]   lo_im_s  [DIV_STAGES];
	logic [QBITS-1:0]   q_re_s   [DIV_STAGES];
	logic [QBITS-1:0]   q_im_s   [DIV_STAGES];
	logic               ovf_re_s [DIV_STAGES];
	logic               ovf_im_s [DIV_STAGES];
	logic [63:0]        den_s    [DIV_STAGES];
	side_t              side_s   [DIV_STAGES];

	assign n_re = {mag_re, {FRAC_BITS{1'b0}}};
	assign n_im = {mag_im, {FRAC_BITS{1'b0}}};

	// range check: quotient of 2^32 or more saturates
	always_ff @(posedge clk) begin
		if (en[0]) begin
			ovf_re_s[0] <= 64'(n_re[NW-1:QBITS]) >= den;
			ovf_im_s[0] <= 64'(n_im[NW-1:QBITS]) >= den;
			rem_re_s[0] <= 64'(n_re[NW-1:QBITS]);
			rem_im_s[0] <= 64'(n_im[NW-1:QBITS]);
			lo_re_s[0]  <= n_re[QBITS-1:0];
			lo_im_s[0]  <= n_im[QBITS-1:0];
			q_re_s[0]   <= '0;
			q_im_s[0]   <= '0;
			den_s[0]    <= den;
			side_s[0]   <= side_in;
		end
	end

	for (genvar j = 1; j < DIV_STAGES; j++) begin : g_step
		logic [64:0] t_re, t_im;
		logic        ge_re, ge_im;

		assign t_re  = {rem_re_s[j-1], lo_re_s[j-1][QBITS-1]};
		assign t_im  = {rem_im_s[j-1], lo_im_s[j-1][QBITS-1]};
		assign ge_re = t_re >= {1'b0, den_s[j-1]};
		assign ge_im = t_im >= {1'b0, den_s[j-1]};

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_re_s[j] <= ge_re ? 64'(t_re - {1'b0, den_s[j-1]}) : t_re[63:0];
				rem_im_s[j] <= ge_im ? 64'(t_im - {1'b0, den_s[j-1]}) : t_im[63:0];
				lo_re_s[j]  <= {lo_re_s[j-1][QBITS-2:0], 1'b0};
				lo_im_s[j]  <= {lo_im_s[j-1][QBITS-2:0], 1'b0};
				q_re_s[j]   <= {q_re_s[j-1][QBITS-2:0], ge_re};
				q_im_s[j]   <= {q_im_s[j-1][QBITS-2:0], ge_im};
				ovf_re_s[j] <= ovf_re_s[j-1];
				ovf_im_s[j] <= ovf_im_s[j-1];
				den_s[j]    <= den_s[j-1];
				side_s[j]   <= side_s[j-1];
			end
		end
	end

	assign q_re     = q_re_s[DIV_STAGES-1];
	assign q_im     = q_im_s[DIV_STAGES-1];
	assign ovf_re   = ovf_re_s[DIV_STAGES-1];
	assign ovf_im   = ovf_im_s[DIV_STAGES-1];
	assign side_out = side_s[DIV_STAGES-1];

endmodule

// ===== rtl/core/complex_arithmetic_unit.sv =====
// complex arithmetic unit top level: stage control and result register
// path from accepted item to result valid: 3 arithmetic stages, 33 divider
// stages, 1 output register; every item takes the full depth; throughput: one
// item per cycle while the output is not stalled; each stage moves on when it
// is empty or its successor moves, so bubbles close up while the output is stalled
// reset clears only the stage valid bits; no clearing pass, ready at once
module complex_arithmetic_unit import cau_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic op_valid,
	output logic op_stall,
	input  op_t  op,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int NST = 3 + DIV_STAGES + 1;

	logic [NST-1:0]     v_q;
	logic [NST:0]       en;
	logic signed [63:0] p1_s1, p2_s1, p3_s1, p4_s1, p5_s1, p6_s1;
	side_t              side_s1, side_s3, side_d;
	logic [63:0]        mag_re_s3, mag_im_s3, den_s3;
	logic [QBITS-1:0]   q_re, q_im;
	logic               ovf_re, ovf_im;
	res_t               res_d;

	assign en[NST] = !res_stall;
	for (genvar k = 0; k < NST; k++) begin : g_en
		assign en[k] = !v_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= op_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign op_stall  = !en[0];
	assign res_valid = v_q[NST-1];

	cau_mult u_mult (
		.clk     (clk),
		.en      (en[0]),
		.op      (op),
		.p1_s1   (p1_s1),
		.p2_s1   (p2_s1),
		.p3_s1   (p3_s1),
		.p4_s1   (p4_s1),
		.p5_s1   (p5_s1),
		.p6_s1   (p6_s1),
		.side_s1 (side_s1)
	);

	cau_comb #(.FRAC_BITS(FRAC_BITS)) u_comb (
		.clk       (clk),
		.en        (en[2:1]),
		.p1_s1     (p1_s1),
		.p2_s1     (p2_s1),
		.p3_s1     (p3_s1),
		.p4_s1     (p4_s1),
		.p5_s1     (p5_s1),
		.p6_s1     (p6_s1),
		.side_s1   (side_s1),
		.mag_re_s3 (mag_re_s3),
		.mag_im_s3 (mag_im_s3),
		.den_s3    (den_s3),
		.side_s3   (side_s3)
	);

	cau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk      (clk),
		.en       (en[3 +: DIV_STAGES]),
		.mag_re   (mag_re_s3),
		.mag_im   (mag_im_s3),
		.den      (den_s3),
		.side_in  (side_s3),
		.q_re     (q_re),
		.q_im     (q_im),
		.ovf_re   (ovf_re),
		.ovf_im   (ovf_im),
		.side_out (side_d)
	);

	always_comb begin
		res_d.flag   = side_d.flag;
		res_d.status = side_d.status;
		if (side_d.div_ok) begin
			res_d.res_re = sat_sm(side_d.neg_re, ovf_re ? 64'h1_0000_0000 : 64'(q_re));
			res_d.res_im = sat_sm(side_d.neg_im, ovf_im ? 64'h1_0000_0000 : 64'(q_im));
		end else begin
			res_d.res_re = side_d.re;
			res_d.res_im = side_d.im;
		end
	end

	always_ff @(posedge clk) begin
		if (en[NST-1]) begin
			res <= res_d;
		end
	end

	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.flag |-> res.res_re == 32'sd0 && res.res_im == 32'sd0)
		else $error("test result carries a nonzero value");

	a_status_noflag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status != ST_OK |-> !res.flag)
		else $error("division status with flag set");

	a_inf_marker: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == ST_INF |-> res.res_re == POS_MAX && res.res_im == 32'sd0)
		else $error("division by zero without infinity marker");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		op_stall |-> v_q[0] && res_valid && res_stall)
		else $error("input stalled with room in the pipeline");

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the complex arithmetic unit
module testbench;
	import cau_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic op_valid = 1'b0;
	logic op_stall;
	op_t op = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	res_t expected_q[$];
	int errors = 0;
	bit stall_free = 1'b0;

	localparam int FRAC = 16;

	complex_arithmetic_unit #(.FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n),
		.op_valid(op_valid), .op_stall(op_stall), .op(op),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	always #2 clk = ~clk;

	initial begin
		#400000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic logic [31:0] clamp(input logic signed [127:0] v);
		logic [31:0] r;
		if (v > 128'sd2147483647) begin
			r = POS_MAX;
		end else if (v < -128'sd2147483648) begin
			r = NEG_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// truncate toward zero after dropping fraction bits
	function automatic logic [31:0] scale_down(input logic signed [127:0] v);
		logic signed [127:0] m;
		m = v < 0 ? -v : v;
		m = m >>> FRAC;
		return clamp(v < 0 ? -m : m);
	endfunction

	function automatic logic [31:0] divide_part(input logic signed [127:0] num,
			input logic signed [127:0] den);
		logic signed [127:0] m, q;
		m = num < 0 ? -num : num;
		q = (m <<< FRAC) / den;
		return clamp(num < 0 ? -q : q);
	endfunction

	function automatic res_t compute_result(input op_t x);
		res_t r;
		logic signed [127:0] ar, ai, br, bi, sc, den;
		r = '0;
		ar = x.a_re; ai = x.a_im; br = x.b_re; bi = x.b_im; sc = x.scalar;
		case (x.kind)
			K_ADD: begin r.res_re = clamp(ar + br); r.res_im = clamp(ai + bi); end
			K_SUB: begin r.res_re = clamp(ar - br); r.res_im = clamp(ai - bi); end
			K_MUL: begin
				r.res_re = scale_down(ar * br - ai * bi);
				r.res_im = scale_down(ar * bi + ai * br);
			end
			K_DIV: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					if (ar != 0 || ai != 0) begin
						r.res_re = POS_MAX;
						r.status = ST_INF;
					end else begin
						r.status = ST_NAN;
					end
				end else begin
					r.res_re = divide_part(ar * br + ai * bi, den);
					r.res_im = divide_part(ai * br - ar * bi, den);
				end
			end
			K_CONJ: begin r.res_re = clamp(ar); r.res_im = clamp(-ai); end
			K_NEG: begin r.res_re = clamp(-ar); r.res_im = clamp(-ai); end
			K_SCALE: begin r.res_re = scale_down(sc * ar); r.res_im = scale_down(sc * ai); end
			K_MODSQ: r.res_re = scale_down(ar * ar + ai * ai);
			K_NONZERO: r.flag = (ar != 0 || ai != 0);
			K_ISINF: r.flag = (x.a_re == POS_MAX && x.a_im == 0);
			default: ;
		endcase
		return r;
	endfunction

	// result side: random stall, compare against oldest expectation
	always @(posedge clk) begin
		res_t want;
		if (res_valid && !res_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, res);
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (res.res_re !== want.res_re)
					$display("%0t: res_re expected %h actual %h", $time, want.res_re, res.res_re);
				if (res.res_im !== want.res_im)
					$display("%0t: res_im expected %h actual %h", $time, want.res_im, res.res_im);
				if (res.flag !== want.flag)
					$display("%0t: flag expected %b actual %b", $time, want.flag, res.flag);
				if (res.status !== want.status)
					$display("%0t: status expected %0d actual %0d", $time, want.status, res.status);
				if (res !== want)
					errors++;
			end
		end
	end

	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_free) begin
			res_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			res_stall <= 1'b1;
		end else if (res_stall) begin
			res_stall <= 1'b0;
		end else begin
			stall_left = $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 0;
			res_stall <= stall_left > 0;
			if (stall_left > 0)
				stall_left--;
		end
	end

	bit sender_gaps = 1'b1;

	task automatic send_item(input op_t x);
		int gap;
		gap = sender_gaps ? ($urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 0) : 0;
		if (gap > 0) begin
			op_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op <= x;
		op_valid <= 1'b1;
		@(posedge clk);
		while (op_stall) @(posedge clk);
		expected_q.push_back(compute_result(x));
	endtask

	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		case ($urandom_range(0, 7))
			0: v = POS_MAX;
			1: v = NEG_MIN;
			2: v = 32'd0;
			3: v = $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
			4: v = {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
			5: v = 32'($signed(16'($urandom)));
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic op_t random_item(input logic [3:0] k);
		op_t x;
		x.kind = k;
		x.a_re = pick_value();
		x.a_im = pick_value();
		x.b_re = pick_value();
		x.b_im = pick_value();
		x.scalar = pick_value();
		if (k == K_DIV && $urandom_range(0, 5) == 0) begin
			x.b_re = 0;
			x.b_im = 0;
		end
		if (k == K_ISINF && $urandom_range(0, 2) == 0) begin
			x.a_re = POS_MAX;
			x.a_im = 0;
		end
		return x;
	endfunction

	task automatic wait_drained();
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		op_t x;
		for (int k = 0; k < 10; k++) begin
			x = '{kind: 4'(k), a_re: POS_MAX, a_im: NEG_MIN, b_re: NEG_MIN,
				b_im: POS_MAX, scalar: NEG_MIN};
			send_item(x);
		end
		send_item('{kind: K_DIV, a_re: 32'h0001_0000, a_im: 0, b_re: 0, b_im: 0, scalar: 0});
		send_item('{kind: K_DIV, a_re: 0, a_im: 0, b_re: 0, b_im: 0, scalar: 0});
		send_item('{kind: K_NEG, a_re: NEG_MIN, a_im: NEG_MIN, b_re: 0, b_im: 0, scalar: 0});
		send_item('{kind: K_ISINF, a_re: POS_MAX, a_im: 0, b_re: 0, b_im: 0, scalar: 0});
		send_item('{kind: K_NONZERO, a_re: 0, a_im: 0, b_re: 0, b_im: 0, scalar: 0});
		send_item('{kind: K_DIV, a_re: POS_MAX, a_im: POS_MAX, b_re: 1, b_im: 0, scalar: 0});
		send_item('{kind: K_MODSQ, a_re: NEG_MIN, a_im: NEG_MIN, b_re: 0, b_im: 0, scalar: 0});
		send_item('{kind: 4'd12, a_re: '1, a_im: '1, b_re: '1, b_im: '1, scalar: '1});
		send_item('{kind: 4'd15, a_re: 0, a_im: 0, b_re: 0, b_im: 0, scalar: 0});
		op_valid <= 1'b0;
		@(posedge clk);
	endtask

	// sender holds off until the pipeline has drained
	task automatic test_drain_pause();
		wait_drained();
		send_item(random_item(K_DIV));
		op_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_random(input int count, input bit gaps);
		sender_gaps = gaps;
		for (int i = 0; i < count; i++)
			send_item(random_item($urandom_range(0, 15) < 13 ? 4'($urandom_range(0, 9))
				: 4'($urandom_range(10, 15))));
		op_valid <= 1'b0;
		@(posedge clk);
		sender_gaps = 1'b1;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_drain_pause();
		test_random(250, 1'b1);
		// back-to-back stretch
		test_random(150, 1'b0);
		@(posedge clk);
		stall_free = 1'b1;
		wait_drained();
		repeat (60) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/cau_pkg.sv
rtl/core/cau_mult.sv
rtl/core/cau_comb.sv
rtl/core/cau_div.sv
rtl/core/complex_arithmetic_unit.sv
verif/testbench.sv
